// ----- design/ptmr_pkg.sv -----
// Shared types and request codes for the ordering table block.
// No dependencies; imported by permutation_table_move_remove.
package ptmr_pkg;

    // Request codes carried in the op field
    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    // Request beat
    typedef struct packed {
        logic [2:0] op;
        logic [6:0] position;
        logic [6:0] other_position;
        logic [6:0] value;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [6:0] data;
        logic       ok;
    } rsp_t;

endpackage

// ----- design/permutation_table_move_remove.sv -----
// Ordering table with rotate and delete: sequencer, table memory, response register.
// Depends on ptmr_pkg for the request and response beat types and op codes.
//
// The table holds DEPTH 7-bit entries and comes out of reset (and out of an init
// request) as identity, using one valid flip-flop per entry, so there is no
// clearing pass. One request is taken at a time and gives exactly one response
// beat. The table sits in a memory with one read and one write port and the
// sequencer walks it one entry per cycle. Write, init and out-of-range requests
// answer straight from idle, read waits on the registered read, find scans up to
// a hit or the last entry, move walks from position to other_position, and remove
// scans the whole table, then shifts and renumbers up to n, the highest position
// whose entry differs from its index (only the scan when the value sits above n
// and the table is left as is). The request side stalls from acceptance until the
// response is loaded into the output register, and while a beat waits under stall.
module permutation_table_move_remove #(
    parameter int DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ptmr_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ptmr_pkg::rsp_t  rsp
);
    import ptmr_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0]    DEPTH_W = 8'(DEPTH);
    localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);
    localparam logic [IW-1:0] ONE     = IW'(1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_RD_WAIT  = 9'b000000010,
        S_FIND     = 9'b000000100,
        S_MV_HOLD  = 9'b000001000,
        S_MV_SHIFT = 9'b000010000,
        S_MV_PLACE = 9'b000100000,
        S_RM_SCAN  = 9'b001000000,
        S_RM_SHIFT = 9'b010000000,
        S_RM_FIX   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] dst_reg, dst_next;
    logic [IW-1:0] s_reg, s_next;
    logic [IW-1:0] n_reg, n_next;
    logic          s_found_reg, s_found_next;
    logic          up_reg, up_next;
    logic [6:0]    held_reg, held_next;
    logic [6:0]    val_reg, val_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_reg, out_next;

    // Table memory and per-entry valid bits (invalid entry reads as its index)
    logic [6:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [6:0]       mem_q;
    logic             rvalid_q;
    logic [IW-1:0]    ridx_q;
    logic [6:0]       rdata;

    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [6:0]    wr_data;
    logic          init_en;

    logic          accept;
    logic          out_free;
    logic          pos_ok, opos_ok, val_ok;
    logic [IW-1:0] pos_i, opos_i;
    logic [IW-1:0] idx_p1, mv_nxt;
    logic          hit, miss;
    logic [IW-1:0] s_cur, n_cur;
    logic [6:0]    dec_data;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign rdata  = rvalid_q ? mem_q : 7'(ridx_q);

    // Operand range checks
    assign pos_ok  = {1'b0, req.position} < DEPTH_W;
    assign opos_ok = {1'b0, req.other_position} < DEPTH_W;
    assign val_ok  = {1'b0, req.value} < DEPTH_W;
    assign pos_i   = req.position[IW-1:0];
    assign opos_i  = req.other_position[IW-1:0];

    // Shared walk arithmetic
    assign idx_p1   = idx_reg + ONE;
    assign mv_nxt   = up_reg ? idx_reg + ONE : idx_reg - ONE;
    assign hit      = rdata == val_reg;
    assign miss     = rdata != 7'(idx_reg);
    assign s_cur    = (!s_found_reg && hit) ? idx_reg : s_reg;
    assign n_cur    = miss ? idx_reg : n_reg;
    assign dec_data = (rdata > val_reg) ? rdata - 7'd1 : rdata;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        s_found_next   = s_found_reg;
        up_next        = up_reg;
        held_next      = held_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rdata;
        init_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (req.op == OP_READ || req.op == OP_MOVE) ? pos_i : '0;
                if (accept)
                begin
                    idx_next     = '0;
                    val_next     = req.value;
                    s_next       = '0;
                    n_next       = '0;
                    s_found_next = 1'b0;
                    out_next     = '{data: 7'd0, ok: 1'b0};
                    case (req.op)
                        OP_READ:
                        begin
                            if (pos_ok)
                                state_next = S_RD_WAIT;
                            else
                                out_valid_next = 1'b1;
                        end
                        OP_FIND:
                        begin
                            state_next = S_FIND;
                        end
                        OP_MOVE:
                        begin
                            if (pos_ok && opos_ok)
                            begin
                                idx_next   = pos_i;
                                dst_next   = opos_i;
                                up_next    = pos_i < opos_i;
                                state_next = S_MV_HOLD;
                            end
                            else
                                out_valid_next = 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            if (val_ok)
                                state_next = S_RM_SCAN;
                            else
                                out_valid_next = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            if (pos_ok)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = pos_i;
                                wr_data     = req.value;
                                out_next.ok = 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_INIT:
                        begin
                            init_en        = 1'b1;
                            out_next.ok    = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                out_next       = '{data: rdata, ok: 1'b1};
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_FIND:
            begin
                if (hit || idx_reg == LAST)
                begin
                    out_next       = '{data: hit ? 7'(idx_reg) : 7'd0, ok: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_p1;
                    rd_addr  = idx_p1;
                end
            end
            S_MV_HOLD:
            begin
                held_next = rdata;
                if (idx_reg == dst_reg)
                    state_next = S_MV_PLACE;
                else
                begin
                    rd_addr    = mv_nxt;
                    state_next = S_MV_SHIFT;
                end
            end
            S_MV_SHIFT:
            begin
                // entry at idx takes its neighbor; read ahead of the write
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rdata;
                idx_next = mv_nxt;
                rd_addr  = up_reg ? mv_nxt + ONE : mv_nxt - ONE;
                if (mv_nxt == dst_reg)
                    state_next = S_MV_PLACE;
            end
            S_MV_PLACE:
            begin
                wr_en          = 1'b1;
                wr_addr        = dst_reg;
                wr_data        = held_reg;
                out_next       = '{data: 7'd0, ok: 1'b1};
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_RM_SCAN:
            begin
                // one pass: first hit on value, last entry off identity
                s_next       = s_cur;
                n_next       = n_cur;
                s_found_next = s_found_reg || hit;
                if (idx_reg == LAST)
                begin
                    idx_next = '0;
                    if (n_cur < s_cur)
                    begin
                        out_next       = '{data: 7'd0, ok: 1'b1};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (n_cur == '0)
                        state_next = S_RM_FIX;
                    else
                    begin
                        rd_addr    = (s_cur == '0) ? ONE : '0;
                        state_next = S_RM_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_p1;
                    rd_addr  = idx_p1;
                end
            end
            S_RM_SHIFT:
            begin
                // shift down above s and renumber in the same walk
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = dec_data;
                if (idx_p1 == n_reg)
                    state_next = S_RM_FIX;
                else
                begin
                    idx_next = idx_p1;
                    rd_addr  = (idx_p1 >= s_reg) ? idx_p1 + ONE : idx_p1;
                end
            end
            S_RM_FIX:
            begin
                wr_en          = 1'b1;
                wr_addr        = n_reg;
                wr_data        = 7'(n_reg);
                out_next       = '{data: 7'd0, ok: 1'b1};
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and valid-bit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (init_en)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        dst_reg     <= dst_next;
        s_reg       <= s_next;
        n_reg       <= n_next;
        s_found_reg <= s_found_next;
        up_reg      <= up_next;
        held_reg    <= held_next;
        val_reg     <= val_next;
        out_reg     <= out_next;
    end

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        mem_q    <= mem[rd_addr];
        rvalid_q <= valid_reg[rd_addr];
        ridx_q   <= rd_addr;
    end

    // Response register is empty whenever the sequencer is busy
    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("response pending while sequencer busy");

    // Every accepted request either answers at once or starts a walk
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE) || out_valid_reg)
        else $error("accepted request dropped");

    // Remove shift never writes at or above the top edited entry
    a_rm_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RM_SHIFT |-> wr_en && (wr_addr < n_reg))
        else $error("remove shift out of bounds");

    // Move shift never reaches the destination slot
    a_mv_shift_dst: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MV_SHIFT |-> idx_reg != dst_reg)
        else $error("move shift overran destination");

endmodule
